// ----- hw/rtl/alstep_pkg.sv -----
// shared types and constants of the antialiased line stepper
`default_nettype none
package alstep_pkg;

  localparam int CIB = 12;  // coordinate integer bits
  localparam int CFB = 8;   // coordinate fraction bits
  localparam int SFB = 16;  // slope and cross position fraction bits

  localparam int COORD_W = CIB + CFB + 1;
  localparam int CLAMP_W = CIB + CFB;
  localparam int PIX_W   = 13;
  localparam int DIM_W   = 13;
  localparam int DIM_MAX = 4096;
  localparam int COV_W   = 8;

  localparam int SLOPE_W = SFB + 2;
  localparam int QUO_W   = SFB + 1;
  localparam int REM_W   = CLAMP_W + 1;
  localparam int CNT_W   = $clog2(QUO_W + 1);
  localparam int COL_W   = CIB + 1;
  localparam int D_W     = CFB + 2;
  localparam int PROD_W  = SLOPE_W + D_W;
  localparam int SUM_W   = CLAMP_W + SFB + 2;
  localparam int CROSS_W = CIB + SFB + 2;
  localparam int ROW_W   = CROSS_W - SFB;
  localparam int GAP_W   = CFB + 1;
  localparam int WT_W    = SFB + 1;
  localparam int CPROD_W = WT_W + GAP_W;
  localparam int COV_SH  = SFB + CFB - 8;
  localparam int CVW_W   = CPROD_W - COV_SH;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_EP0,
    ST_EP1,
    ST_EMIT0,
    ST_EMIT1
  } back_state_e;

  // classified command, endpoints clamped, swapped and ordered
  typedef struct packed {
    cmd_e               cmd;
    logic               steep;
    logic [CLAMP_W-1:0] x0;
    logic [CLAMP_W-1:0] y0;
    logic [CLAMP_W-1:0] x1;
    logic [CLAMP_W-1:0] y1;
  } alstep_entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } alstep_qctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } alstep_qsts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/alstep_front.sv -----
// front end: frame registers, endpoint clamping and major-axis classification
`default_nettype none
module alstep_front
  import alstep_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_index_i,
  input  wire logic [DIM_W-1:0]   cfg_data_i,
  input  wire logic               cmd_i,
  input  wire logic [COORD_W-1:0] start_x_i,
  input  wire logic [COORD_W-1:0] start_y_i,
  input  wire logic [COORD_W-1:0] end_x_i,
  input  wire logic [COORD_W-1:0] end_y_i,
  output alstep_entry_t           entry_o
);

  localparam int LIM_W = DIM_W + CFB;

  logic [DIM_W-1:0] frame_width_q, frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= DIM_W'(640);
      frame_height_q <= DIM_W'(480);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic logic [LIM_W-1:0] max_coord(input logic [DIM_W-1:0] dim);
    logic [DIM_W-1:0] d;
    d = dim;
    if (dim == '0) d = DIM_W'(1);
    else if (dim > DIM_W'(DIM_MAX)) d = DIM_W'(DIM_MAX);
    return {d - DIM_W'(1), {CFB{1'b0}}};
  endfunction

  function automatic logic [CLAMP_W-1:0] clamp(input logic [COORD_W-1:0] v,
                                               input logic [LIM_W-1:0] lim);
    logic [CLAMP_W-1:0] r;
    if (v[COORD_W-1]) r = '0;
    else if ({1'b0, v[COORD_W-2:0]} > {{(COORD_W-CLAMP_W){1'b0}}, CLAMP_W'(lim)} ||
             LIM_W'(v[COORD_W-2:0]) > lim)
      r = CLAMP_W'(lim);
    else r = v[CLAMP_W-1:0];
    return r;
  endfunction

  logic [LIM_W-1:0]   wmax, hmax;
  logic [CLAMP_W-1:0] ax0, ay0, ax1, ay1, adx, ady;
  logic [CLAMP_W-1:0] mx0, my0, mx1, my1;
  logic               steep;

  always_comb begin
    wmax  = max_coord(frame_width_q);
    hmax  = max_coord(frame_height_q);
    ax0   = clamp(start_x_i, wmax);
    ay0   = clamp(start_y_i, hmax);
    ax1   = clamp(end_x_i, wmax);
    ay1   = clamp(end_y_i, hmax);
    adx   = (ax1 > ax0) ? ax1 - ax0 : ax0 - ax1;
    ady   = (ay1 > ay0) ? ay1 - ay0 : ay0 - ay1;
    steep = ady > adx;
    mx0   = steep ? ay0 : ax0;
    my0   = steep ? ax0 : ay0;
    mx1   = steep ? ay1 : ax1;
    my1   = steep ? ax1 : ay1;
    entry_o.cmd   = cmd_e'(cmd_i);
    entry_o.steep = steep;
    // order along the major axis
    if (mx0 > mx1) begin
      entry_o.x0 = mx1;
      entry_o.y0 = my1;
      entry_o.x1 = mx0;
      entry_o.y1 = my0;
    end else begin
      entry_o.x0 = mx0;
      entry_o.y0 = my0;
      entry_o.x1 = mx1;
      entry_o.y1 = my1;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/alstep_queue.sv -----
// two-entry command queue between front end and back end
`default_nettype none
module alstep_queue
  import alstep_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  alstep_qctl_t ctl_i,
  input  alstep_entry_t wr_data_i,
  output alstep_entry_t rd_data_o,
  output alstep_qsts_t sts_o
);

  alstep_entry_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign sts_o.full  = count_q == 2'd2;
  assign sts_o.empty = count_q == 2'd0;
  assign do_push     = ctl_i.push && !sts_o.full;
  assign do_pop      = ctl_i.pop && !sts_o.empty;
  assign rd_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop) rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/alstep_back.sv -----
// back end: slope divider, endpoint set-up, column stepping and pixel output
`default_nettype none
module alstep_back
  import alstep_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  alstep_entry_t         entry_i,
  input  alstep_qsts_t          qsts_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [PIX_W-1:0]      pixel_x_o,
  output logic [PIX_W-1:0]      pixel_y_o,
  output logic [COV_W-1:0]      coverage_o,
  output logic                  line_done_o,
  output logic                  last_o
);

  localparam logic [GAP_W-1:0] GAP_ONE = GAP_W'(1) << CFB;
  localparam logic [CLAMP_W:0] HALF_X  = (CLAMP_W+1)'(1) << (CFB - 1);
  localparam logic [WT_W-1:0]  WT_ONE  = WT_W'(1) << SFB;

  back_state_e state_q, state_d;
  logic active_q, active_d;
  logic out_valid_q, out_valid_d;

  logic               steep_q, steep_d;
  logic [CLAMP_W-1:0] x0_q, x0_d, y0_q, y0_d, x1_q, x1_d, y1_q, y1_d;
  logic [CLAMP_W-1:0] dx_q, dx_d, wk_y_q, wk_y_d;
  logic               dyneg_q, dyneg_d, ep_sel_q, ep_sel_d;
  logic [REM_W-1:0]   rem_q, rem_d;
  logic [QUO_W-1:0]   quo_q, quo_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [SLOPE_W-1:0] slope_q, slope_d;
  logic [CROSS_W-1:0] cross_q, cross_d, wk_ey_q, wk_ey_d;
  logic [PIX_W-1:0]   cur_q, cur_d, final_q, final_d, c0_q, c0_d, col_q, col_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [GAP_W-1:0]   gap_q, gap_d;
  logic               wk_done_q, wk_done_d, wk_last_q, wk_last_d;
  logic [PIX_W-1:0]   px_q, px_d, py_q, py_d;
  logic [COV_W-1:0]   cov_q, cov_d;
  logic               done_q, done_d, last_q, last_d;

  // scratch
  logic [CLAMP_W:0]   dy_s, ep_x, xh;
  logic               ge, shrt, load_out, k;
  logic [REM_W-1:0]   r1;
  logic [QUO_W-1:0]   quo_n;
  logic [COL_W-1:0]   xr;
  logic [D_W-1:0]     dd;
  logic [SUM_W-1:0]   sum;
  logic [ROW_W-1:0]   row;
  logic [SFB-1:0]     fr;
  logic [WT_W-1:0]    wt;
  logic [CPROD_W-1:0] cp;
  logic [CVW_W-1:0]   cvw;
  logic [PIX_W-1:0]   prow;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    steep_q <= steep_d;  x0_q <= x0_d;  y0_q <= y0_d;  x1_q <= x1_d;  y1_q <= y1_d;
    dx_q <= dx_d;  wk_y_q <= wk_y_d;  dyneg_q <= dyneg_d;  ep_sel_q <= ep_sel_d;
    rem_q <= rem_d;  quo_q <= quo_d;  cnt_q <= cnt_d;  slope_q <= slope_d;
    cross_q <= cross_d;  wk_ey_q <= wk_ey_d;  cur_q <= cur_d;  final_q <= final_d;
    c0_q <= c0_d;  col_q <= col_d;  prod_q <= prod_d;  gap_q <= gap_d;
    wk_done_q <= wk_done_d;  wk_last_q <= wk_last_d;
    px_q <= px_d;  py_q <= py_d;  cov_q <= cov_d;  done_q <= done_d;  last_q <= last_d;
  end

  // pixel of the column in the work registers, k selects the lower pixel
  always_comb begin
    k   = state_q == ST_EMIT1;
    row = wk_ey_q[CROSS_W-1:SFB] + ROW_W'(k);
    fr  = wk_ey_q[SFB-1:0];
    wt  = k ? {1'b0, fr} : WT_ONE - {1'b0, fr};
    cp  = CPROD_W'(wt) * CPROD_W'(gap_q);
    cvw = cp[CPROD_W-1:COV_SH];
    // rows above the frame are reported as row zero
    prow = row[ROW_W-1] ? '0 : PIX_W'(row);
  end

  always_comb begin
    state_d = state_q;  active_d = active_q;
    steep_d = steep_q;  x0_d = x0_q;  y0_d = y0_q;  x1_d = x1_q;  y1_d = y1_q;
    dx_d = dx_q;  wk_y_d = wk_y_q;  dyneg_d = dyneg_q;  ep_sel_d = ep_sel_q;
    rem_d = rem_q;  quo_d = quo_q;  cnt_d = cnt_q;  slope_d = slope_q;
    cross_d = cross_q;  wk_ey_d = wk_ey_q;  cur_d = cur_q;  final_d = final_q;
    c0_d = c0_q;  col_d = col_q;  prod_d = prod_q;  gap_d = gap_q;
    wk_done_d = wk_done_q;  wk_last_d = wk_last_q;
    pop_o = 1'b0;  load_out = 1'b0;
    dy_s = '0;  ep_x = '0;  xh = '0;  xr = '0;  dd = '0;  sum = '0;
    ge = 1'b0;  r1 = '0;  quo_n = '0;  shrt = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (!qsts_i.empty) begin
          pop_o = 1'b1;
          if (entry_i.cmd == CMD_START) begin
            steep_d = entry_i.steep;
            x0_d = entry_i.x0;  y0_d = entry_i.y0;
            x1_d = entry_i.x1;  y1_d = entry_i.y1;
            dx_d = entry_i.x1 - entry_i.x0;
            dy_s = {1'b0, entry_i.y1} - {1'b0, entry_i.y0};
            dyneg_d = dy_s[CLAMP_W];
            rem_d = dy_s[CLAMP_W] ? REM_W'(-dy_s) : REM_W'(dy_s);
            quo_d = '0;
            cnt_d = '0;
            state_d = ST_DIV;
          end else if (active_q) begin
            wk_ey_d   = cross_q;
            gap_d     = GAP_ONE;
            col_d     = cur_q;
            wk_done_d = cur_q >= final_q;
            wk_last_d = 1'b1;
            cross_d   = cross_q + {{(CROSS_W-SLOPE_W){slope_q[SLOPE_W-1]}}, slope_q};
            cur_d     = cur_q + PIX_W'(1);
            if (cur_q >= final_q) active_d = 1'b0;
            state_d = ST_EMIT0;
          end
        end
      end
      ST_DIV: begin
        // restoring division, one quotient bit per cycle
        ge    = rem_q >= {1'b0, dx_q};
        r1    = ge ? rem_q - {1'b0, dx_q} : rem_q;
        quo_n = {quo_q[QUO_W-2:0], ge};
        quo_d = quo_n;
        rem_d = {r1[REM_W-2:0], 1'b0};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(QUO_W - 1)) begin
          if (dx_q == '0) slope_d = '0;
          else if (dyneg_q) slope_d = SLOPE_W'(-{1'b0, quo_n});
          else slope_d = {1'b0, quo_n};
          ep_sel_d = 1'b0;
          state_d  = ST_EP0;
        end
      end
      ST_EP0: begin
        ep_x   = {1'b0, ep_sel_q ? x1_q : x0_q};
        wk_y_d = ep_sel_q ? y1_q : y0_q;
        xh     = ep_x + HALF_X;
        xr     = xh[CLAMP_W:CFB];
        // distance from the endpoint to its rounded column
        dd     = D_W'(HALF_X[CFB-1:0]) - D_W'(xh[CFB-1:0]);
        prod_d = PROD_W'($signed(slope_q)) * PROD_W'($signed(dd));
        gap_d  = GAP_ONE - GAP_W'(xh[CFB-1:0]);
        col_d  = PIX_W'(xr);
        if (!ep_sel_q) begin
          c0_d      = PIX_W'(xr);
          wk_done_d = 1'b0;
          wk_last_d = 1'b0;
        end else begin
          shrt      = {1'b0, PIX_W'(xr)} <= {1'b0, c0_q} + (PIX_W+1)'(1);
          wk_done_d = shrt;
          wk_last_d = 1'b1;
          active_d  = !shrt;
          cur_d     = c0_q + PIX_W'(1);
          final_d   = shrt ? '0 : PIX_W'(xr) - PIX_W'(1);
        end
        state_d = ST_EP1;
      end
      ST_EP1: begin
        sum = {2'b00, wk_y_q, {SFB{1'b0}}} +
              {{(SUM_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
        wk_ey_d = sum[SUM_W-1:CFB];
        if (!ep_sel_q)
          cross_d = sum[SUM_W-1:CFB] +
                    {{(CROSS_W-SLOPE_W){slope_q[SLOPE_W-1]}}, slope_q};
        state_d = ST_EMIT0;
      end
      ST_EMIT0: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = ST_EMIT1;
        end
      end
      ST_EMIT1: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          if (wk_last_q) state_d = ST_IDLE;
          else begin
            ep_sel_d = 1'b1;
            state_d  = ST_EP0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    px_d = px_q;  py_d = py_q;  cov_d = cov_q;  done_d = done_q;  last_d = last_q;
    if (load_out) begin
      px_d   = steep_q ? prow : col_q;
      py_d   = steep_q ? col_q : prow;
      cov_d  = (cvw > CVW_W'(255)) ? COV_W'(255) : COV_W'(cvw);
      done_d = k && wk_done_q;
      last_d = k && wk_last_q;
    end
    if (load_out) out_valid_d = 1'b1;
    else if (out_stall_i) out_valid_d = out_valid_q;
    else out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = px_q;
  assign pixel_y_o   = py_q;
  assign coverage_o  = cov_q;
  assign line_done_o = done_q;
  assign last_o      = last_q;

endmodule
`default_nettype wire

// ----- hw/rtl/antialiased_line_stepper.sv -----
// Wu antialiased line stepper: accepts a start command (4 pixels out) or a step command
// (2 pixels out, none when no line is active). The back end pops a start, runs it through
// the bit-serial slope divider, then per endpoint passes two set-up states and emits that
// endpoint's two pixels. A step loads the column and then emits its two pixels.
// A two-entry queue lets commands arrive while the back end is busy; the front end stalls
// only when that queue is full.
`default_nettype none
module antialiased_line_stepper
  import alstep_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_index_i,
  input  wire logic [DIM_W-1:0]   cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               cmd_i,
  input  wire logic [COORD_W-1:0] start_x_i,
  input  wire logic [COORD_W-1:0] start_y_i,
  input  wire logic [COORD_W-1:0] end_x_i,
  input  wire logic [COORD_W-1:0] end_y_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [PIX_W-1:0]        pixel_x_o,
  output logic [PIX_W-1:0]        pixel_y_o,
  output logic [COV_W-1:0]        coverage_o,
  output logic                    line_done_o,
  output logic                    last_o
);

  alstep_entry_t front_entry, queue_entry;
  alstep_qctl_t  qctl;
  alstep_qsts_t  qsts;
  logic          pop;

  alstep_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .cmd_i, .start_x_i, .start_y_i, .end_x_i, .end_y_i,
    .entry_o (front_entry)
  );

  assign qctl.push  = in_valid_i;
  assign qctl.pop   = pop;
  assign in_stall_o = qsts.full;

  alstep_queue u_queue (
    .clk_i, .rst_ni,
    .ctl_i     (qctl),
    .wr_data_i (front_entry),
    .rd_data_o (queue_entry),
    .sts_o     (qsts)
  );

  alstep_back u_back (
    .clk_i, .rst_ni,
    .entry_i (queue_entry),
    .qsts_i  (qsts),
    .pop_o   (pop),
    .out_valid_o, .out_stall_i,
    .pixel_x_o, .pixel_y_o, .coverage_o, .line_done_o, .last_o
  );

endmodule
`default_nettype wire

// ----- tb/antialiased_line_stepper_test.sv -----
// self-checking testbench of the antialiased line stepper
`default_nettype none
module antialiased_line_stepper_test
  import alstep_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCH_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE = 40;

  typedef struct {
    cmd_e                      cmd;
    logic signed [COORD_W-1:0] sx, sy, ex, ey;
  } line_cmd_t;

  typedef struct {
    logic [PIX_W-1:0] px, py;
    logic [COV_W-1:0] cov;
    logic             done, last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [DIM_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic cmd = 1'b0;
  logic [COORD_W-1:0] sx = '0, sy = '0, ex = '0, ey = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PIX_W-1:0] pixel_x, pixel_y;
  logic [COV_W-1:0] coverage;
  logic line_done, last;

  antialiased_line_stepper u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .cmd_i(cmd), .start_x_i(sx), .start_y_i(sy), .end_x_i(ex), .end_y_i(ey),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .pixel_x_o(pixel_x), .pixel_y_o(pixel_y), .coverage_o(coverage),
    .line_done_o(line_done), .last_o(last)
  );

  always #2 clk = ~clk;

  line_cmd_t pending_cmds[$];
  line_cmd_t cur_cmd;
  pixel_t    expected_pixels[$];
  int errors = 0;
  int n_starts = 0, n_steps = 0, n_pixels = 0;
  bit quiet = 1'b0;
  int hold_req = 0, hold_seen = 0, hold_cnt = 0;

  // line stepper state mirror
  logic [DIM_W-1:0] frame_w = 13'd640, frame_h = 13'd480;
  bit               ln_active = 1'b0, ln_steep = 1'b0;
  logic [PIX_W-1:0] col_next = '0, col_final = '0;
  longint           cross_pos = 0, grad = 0;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic longint dim_clamp(logic [DIM_W-1:0] d);
    if (d < 1) return 1;
    if (d > DIM_MAX) return DIM_MAX;
    return d;
  endfunction

  function automatic longint clampv(longint v, longint hi);
    return v < 0 ? 0 : (v > hi ? hi : v);
  endfunction

  function automatic void push_pixel(longint col, longint row, longint cv, bit done);
    pixel_t p;
    if (row < 0) row = 0;
    if (col < 0) col = 0;
    p.px = ln_steep ? row[PIX_W-1:0] : col[PIX_W-1:0];
    p.py = ln_steep ? col[PIX_W-1:0] : row[PIX_W-1:0];
    p.cov = cv > 255 ? 8'd255 : cv[7:0];
    p.done = done;
    p.last = 1'b0;
    expected_pixels.push_back(p);
  endfunction

  // endpoint column pair, returns the cross position there
  function automatic longint shade_endpoint(longint x, longint y, bit done);
    longint xr, d, e, gap, row, fr;
    xr = (x + (1 << (CFB - 1))) >>> CFB;
    d = (xr << CFB) - x;
    e = ((y << SFB) + grad * d) >>> CFB;
    gap = (1 << CFB) - ((x + (1 << (CFB - 1))) & ((1 << CFB) - 1));
    row = e >>> SFB;
    fr = e - (row << SFB);
    push_pixel(xr, row, (((1 << SFB) - fr) * gap) >> COV_SH, 1'b0);
    push_pixel(xr, row + 1, (fr * gap) >> COV_SH, done);
    return e;
  endfunction

  function automatic void predict_line(line_cmd_t c);
    longint wmax, hmax, x0, y0, x1, y1, t, dx, dy, adx, ady, c0, c1, e0, mag, row, fr;
    bit shrt, done;
    if (c.cmd == CMD_START) begin
      n_starts++;
      wmax = (dim_clamp(frame_w) - 1) << CFB;
      hmax = (dim_clamp(frame_h) - 1) << CFB;
      x0 = clampv(longint'(c.sx), wmax);
      y0 = clampv(longint'(c.sy), hmax);
      x1 = clampv(longint'(c.ex), wmax);
      y1 = clampv(longint'(c.ey), hmax);
      adx = x1 > x0 ? x1 - x0 : x0 - x1;
      ady = y1 > y0 ? y1 - y0 : y0 - y1;
      ln_steep = ady > adx;
      if (ln_steep) begin
        t = x0; x0 = y0; y0 = t;
        t = x1; x1 = y1; y1 = t;
      end
      if (x0 > x1) begin
        t = x0; x0 = x1; x1 = t;
        t = y0; y0 = y1; y1 = t;
      end
      dx = x1 - x0;
      dy = y1 - y0;
      if (dx == 0) begin
        grad = 0;
      end else begin
        mag = ((dy < 0 ? -dy : dy) << SFB) / dx;
        grad = dy < 0 ? -mag : mag;
      end
      c0 = (x0 + (1 << (CFB - 1))) >>> CFB;
      c1 = (x1 + (1 << (CFB - 1))) >>> CFB;
      shrt = c1 <= c0 + 1;
      e0 = shade_endpoint(x0, y0, 1'b0);
      void'(shade_endpoint(x1, y1, shrt));
      cross_pos = e0 + grad;
      ln_active = !shrt;
      col_next = PIX_W'(c0 + 1);
      col_final = shrt ? '0 : PIX_W'(c1 - 1);
    end else begin
      n_steps++;
      if (!ln_active) return;
      row = cross_pos >>> SFB;
      fr = cross_pos - (row << SFB);
      done = col_next >= col_final;
      push_pixel(col_next, row, ((1 << SFB) - fr) >> (SFB - 8), 1'b0);
      push_pixel(col_next, row + 1, fr >> (SFB - 8), done);
      cross_pos += grad;
      col_next = col_next + 1'b1;
      if (done) ln_active = 1'b0;
    end
    expected_pixels[$].last = 1'b1;
  endfunction

  // sender
  always @(posedge clk) begin
    if (in_valid && !in_stall) predict_line(cur_cmd);
    if (!in_valid || !in_stall) begin
      if (pending_cmds.size() != 0 && (quiet || $urandom_range(99) >= 23)) begin
        cur_cmd = pending_cmds.pop_front();
        in_valid <= 1'b1;
        cmd <= cur_cmd.cmd;
        sx <= cur_cmd.sx;
        sy <= cur_cmd.sy;
        ex <= cur_cmd.ex;
        ey <= cur_cmd.ey;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    pixel_t w;
    if (out_valid && !out_stall) begin
      n_pixels++;
      if (expected_pixels.size() == 0) begin
        $display("unexpected pixel transfer x=%0d y=%0d", pixel_x, pixel_y);
        errors++;
      end else begin
        w = expected_pixels.pop_front();
        if (pixel_x !== w.px) report_mismatch("pixel_x", pixel_x, w.px);
        if (pixel_y !== w.py) report_mismatch("pixel_y", pixel_y, w.py);
        if (coverage !== w.cov) report_mismatch("coverage", coverage, w.cov);
        if (line_done !== w.done) report_mismatch("line_done", line_done, w.done);
        if (last !== w.last) report_mismatch("last", last, w.last);
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= hold_cnt != 1;
    end else begin
      out_stall <= !quiet && $urandom_range(99) < 23;
    end
  end

  // watchdog on cycles with no transfer at all
  int stuck = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= WATCH_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [DIM_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_FRAME_WIDTH) frame_w = val;
    else frame_h = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    while (pending_cmds.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic add_line(longint x0, longint y0, longint x1, longint y1);
    line_cmd_t c;
    c.cmd = CMD_START;
    c.sx = x0; c.sy = y0; c.ex = x1; c.ey = y1;
    pending_cmds.push_back(c);
  endtask

  task automatic add_steps(int n);
    line_cmd_t c;
    repeat (n) begin
      c.cmd = CMD_STEP;
      c.sx = $urandom; c.sy = $urandom; c.ex = $urandom; c.ey = $urandom;
      pending_cmds.push_back(c);
    end
  endtask

  // short random line inside or near the frame (now and then one with fully random endpoints), then steps to walk it
  task automatic add_random_line;
    longint w, h, x0, y0, x1, y1;
    w = dim_clamp(frame_w) << CFB;
    h = dim_clamp(frame_h) << CFB;
    if ($urandom_range(9) == 0) begin
      add_line($signed(21'($urandom)), $signed(21'($urandom)),
               $signed(21'($urandom)), $signed(21'($urandom)));
    end else begin
      x0 = longint'($urandom_range(w + 8192)) - 4096;
      y0 = longint'($urandom_range(h + 8192)) - 4096;
      x1 = x0 + longint'($urandom_range(20480)) - 10240;
      y1 = y0 + longint'($urandom_range(20480)) - 10240;
      add_line(x0, y0, x1, y1);
    end
    add_steps($urandom_range(45));
  endtask

  task automatic random_phase(int n);
    int target;
    target = pending_cmds.size() + n;
    while (pending_cmds.size() < target) add_random_line();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, idle step, orientations, short lines, restart
    add_steps(1);
    add_line(0, 0, 0, 0);
    add_line(21'sh0FFFFF, 21'sh0FFFFF, -21'sh100000, -21'sh100000);
    add_line(0, 0, 0, 0);
    add_line(256 * 5 + 64, 256 * 7, 256 * 6, 256 * 7 + 100);
    add_line(256 * 2, 256 * 10, 256 * 12, 256 * 10);
    add_steps(10);
    add_line(256 * 3, 256 * 2, 256 * 3, 256 * 9 + 30);
    add_steps(7);
    add_line(256 * 20, 256 * 20, 256 * 4, 256 * 4);
    add_steps(2);
    add_line(256 * 10 + 70, 0, 256 * 30, 256 * 8);
    add_steps(20);
    add_line(256 * 639 + 255, 256 * 479 + 200, 256 * 600, 256 * 470);
    add_steps(3);
    drain();

    // back to back stretch with no idling on either side
    quiet = 1'b1;
    random_phase(20);
    drain();
    quiet = 1'b0;

    write_reg(REG_FRAME_WIDTH, 13'd1);
    write_reg(REG_FRAME_HEIGHT, 13'd1);
    add_line(256 * 3, 256 * 3, 256 * 9, 256 * 2);
    add_steps(2);
    random_phase(8);
    drain();

    write_reg(REG_FRAME_WIDTH, 13'd4096);
    write_reg(REG_FRAME_HEIGHT, 13'd4096);
    add_line(-21'sh100000, 21'sh0FFFFF, 21'sh0FFFFF, -21'sh100000);
    add_line(256 * 4090, 256 * 4095 + 255, 256 * 4095 + 255, 256 * 4085);
    add_steps(6);
    random_phase(30);
    hold_req++;
    drain();

    write_reg(REG_FRAME_WIDTH, 13'd0);
    write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
    random_phase(10);
    drain();

    write_reg(REG_FRAME_WIDTH, 13'($urandom_range(200, 20)));
    write_reg(REG_FRAME_HEIGHT, 13'($urandom_range(200, 20)));
    random_phase(20);
    drain();

    $display("covered %0d line starts and %0d column steps, %0d pixels checked",
             n_starts, n_steps, n_pixels);
    $display("frame sizes 1x1, 4096x4096, out-of-range and random; one long output hold");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
hw/rtl/alstep_pkg.sv
hw/rtl/alstep_front.sv
hw/rtl/alstep_queue.sv
hw/rtl/alstep_back.sv
hw/rtl/antialiased_line_stepper.sv
tb/antialiased_line_stepper_test.sv
